@@ hw/rtl/stbg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stbg_pkg
// Shared widths, reset values, register indexes and the side-band record that
// travels with each sample through the tone burst generator pipeline.
// ----------------------------------------------------------------------------
package stbg_pkg;

    // Field widths of the streaming and configuration ports.
    localparam int IDX_IN_W   = 20;
    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 15;
    localparam int AMP_W      = 15;
    localparam int STEP_W     = 32;
    localparam int SPH_W      = 16;
    localparam int LEN_W      = 20;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // Envelope is a Q16 fraction in 0..1, so it needs one bit above the point.
    localparam int ENV_FRAC = 16;
    localparam int ENV_W    = ENV_FRAC + 1;
    localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(1) << ENV_FRAC;

    // Envelope numerator and denominator are products of two ramp counts.
    localparam int PROD_W      = 2 * LEN_W;
    localparam int MA_W        = MAG_W + AMP_W;
    localparam int TONE_PROD_W = MA_W + ENV_W;

    localparam int FULL_SCALE = 32767;

    // 2*pi in Q30, used to build the quarter-wave table.
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // Register reset values.
    localparam logic [STEP_W-1:0] RST_PHASE_STEP   = 32'd48695777;
    localparam logic [SPH_W-1:0]  RST_START_PHASE  = 16'd0;
    localparam logic [AMP_W-1:0]  RST_PEAK_AMP     = 15'd16384;
    localparam logic [LEN_W-1:0]  RST_BURST_START  = 20'd0;
    localparam logic [LEN_W-1:0]  RST_BURST_LENGTH = 20'd11025;
    localparam logic [LEN_W-1:0]  RST_RAMP_LENGTH  = 20'd4410;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP   = 3'd0,
        REG_START_PHASE  = 3'd1,
        REG_PEAK_AMP     = 3'd2,
        REG_BURST_START  = 3'd3,
        REG_BURST_LENGTH = 3'd4,
        REG_RAMP_LENGTH  = 3'd5
    } stbg_cfg_reg_t;

    // Per-sample side band carried alongside the arithmetic.
    typedef struct packed {
        logic                       valid;
        logic                       win;
        logic                       neg;
        logic [MAG_W-1:0]           mag;
        logic signed [SAMPLE_W-1:0] mix;
    } stbg_tag_t;

endpackage : stbg_pkg
`default_nettype wire

@@ hw/rtl/sine_tone_burst_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sine_tone_burst_generator
// DDS sine tone, gated to a burst window with linear attack and release
// ramps, scaled and mixed into an incoming sample stream with saturation.
// ----------------------------------------------------------------------------
// The block takes one request per clock unless frozen and returns one result
// per request, in order: five stages build the phase, the ramp counts and
// the table address, a 17-stage divider forms the Q16 envelope (one quotient
// bit per stage), three stages scale the tone, and the output register holds
// the saturated sum. When the result side stalls, the result that was on its
// way lands in a one-entry skid register and the whole pipeline freezes until
// that entry drains, so no request is dropped or duplicated. Each sample's
// phase is (start_phase << 16) + index * phase_step, taken modulo one turn;
// the table index is the top bits of phase times SINE_TABLE_DEPTH, folded into
// a quarter-wave table of SINE_TABLE_DEPTH/4 + 1 entries that is built at
// elaboration. Only the low INDEX_BITS bits of the sample index are used.
// Configuration writes take effect at once and must only be issued while the
// pipeline is empty.
// ----------------------------------------------------------------------------
module sine_tone_burst_generator import stbg_pkg::*; #(
    parameter int INDEX_BITS       = 20,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // Configuration write port.
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,
    // Sample requests.
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [IDX_IN_W-1:0]        s_sample_index,
    input  wire logic signed [SAMPLE_W-1:0] s_mix_in,
    // Mixed results.
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_sample_out
);

    // Usable index bits never exceed the width of the index port.
    localparam int IDX_W   = (INDEX_BITS < IDX_IN_W) ? INDEX_BITS : IDX_IN_W;
    localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int K_W     = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR     = SINE_TABLE_DEPTH / 4;
    localparam int ROM_AW  = $clog2(QTR + 1);
    localparam int KP_W    = STEP_W + DEPTH_W;
    localparam int X_W     = TONE_PROD_W - ENV_FRAC;
    localparam int XH_W    = X_W - MAG_W;

    localparam logic [K_W:0]    QTR1  = (K_W+1)'(QTR);
    localparam logic [K_W:0]    QTR2  = (K_W+1)'(2 * QTR);
    localparam logic [K_W:0]    QTR3  = (K_W+1)'(3 * QTR);
    localparam logic [K_W:0]    QTR4  = (K_W+1)'(4 * QTR);
    localparam logic [ROM_AW-1:0] QTR_A = ROM_AW'(QTR);

    localparam logic signed [SAMPLE_W:0] SUM_MAX = 17'sd32767;
    localparam logic signed [SAMPLE_W:0] SUM_MIN = -17'sd32768;

    // Quarter-wave entry m: round(32767 * sin(2*pi*m/DEPTH)) from an 11th
    // order Taylor series in Q30. Evaluated only while building the table.
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned m);
        logic        [63:0] x;
        logic        [63:0] x2;
        logic        [63:0] term;
        logic        [63:0] v;
        logic signed [63:0] sum;
        x    = (64'(m) * TWO_PI_Q30) / 64'(SINE_TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        if (sum < 0) begin
            sum = '0;
        end
        v = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        return (v > 64'd32767) ? MAG_W'(FULL_SCALE) : v[MAG_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [STEP_W-1:0] phase_step_reg;
    logic [SPH_W-1:0]  start_phase_reg;
    logic [AMP_W-1:0]  peak_amp_reg;
    logic [LEN_W-1:0]  burst_start_reg;
    logic [LEN_W-1:0]  burst_length_reg;
    logic [LEN_W-1:0]  ramp_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg   <= RST_PHASE_STEP;
            start_phase_reg  <= RST_START_PHASE;
            peak_amp_reg     <= RST_PEAK_AMP;
            burst_start_reg  <= RST_BURST_START;
            burst_length_reg <= RST_BURST_LENGTH;
            ramp_length_reg  <= RST_RAMP_LENGTH;
        end else if (cfg_we) begin
            case (stbg_cfg_reg_t'(cfg_index))
                REG_PHASE_STEP:   phase_step_reg   <= cfg_data[STEP_W-1:0];
                REG_START_PHASE:  start_phase_reg  <= cfg_data[SPH_W-1:0];
                REG_PEAK_AMP:     peak_amp_reg     <= cfg_data[AMP_W-1:0];
                REG_BURST_START:  burst_start_reg  <= cfg_data[LEN_W-1:0];
                REG_BURST_LENGTH: burst_length_reg <= cfg_data[LEN_W-1:0];
                REG_RAMP_LENGTH:  ramp_length_reg  <= cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline control. The pipeline moves as one whenever the skid register
    // is empty; a full skid register freezes every stage.
    // ------------------------------------------------------------------------
    logic pipe_en;
    logic skid_valid_reg;

    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;

    // ------------------------------------------------------------------------
    // Stage 1: index masking, window test, raw ramp counts, phase product.
    // ------------------------------------------------------------------------
    logic [IDX_W-1:0]  idx_w;
    logic [LEN_W-1:0]  idx_l;
    logic [LEN_W:0]    burst_end;

    stbg_tag_t         s1_tag_reg, s1_tag_next;
    logic [STEP_W-1:0] s1_phinc_reg, s1_phinc_next;
    logic [LEN_W-1:0]  s1_att_reg, s1_att_next;
    logic [LEN_W:0]    s1_rel_reg, s1_rel_next;
    logic [LEN_W-1:0]  s1_ramp_reg, s1_ramp_next;

    assign idx_w     = s_sample_index[IDX_W-1:0];
    assign idx_l     = LEN_W'(idx_w);
    assign burst_end = {1'b0, burst_start_reg} + {1'b0, burst_length_reg};

    always_comb begin
        s1_tag_next.valid = s_valid;
        s1_tag_next.win   = (idx_l >= burst_start_reg) && ({1'b0, idx_l} < burst_end);
        s1_tag_next.neg   = 1'b0;
        s1_tag_next.mag   = '0;
        s1_tag_next.mix   = s_mix_in;
        s1_phinc_next     = STEP_W'(idx_w) * phase_step_reg;
        s1_att_next       = idx_l - burst_start_reg;
        s1_rel_next       = burst_end - {1'b0, idx_l};
        // A zero ramp length behaves as a ramp of one sample.
        s1_ramp_next      = (ramp_length_reg == '0) ? LEN_W'(1) : ramp_length_reg;
    end

    // ------------------------------------------------------------------------
    // Stage 2: full phase word, ramp counts clamped to the ramp length.
    // ------------------------------------------------------------------------
    stbg_tag_t         s2_tag_reg, s2_tag_next;
    logic [STEP_W-1:0] s2_phase_reg, s2_phase_next;
    logic [LEN_W-1:0]  s2_att_reg, s2_att_next;
    logic [LEN_W-1:0]  s2_rel_reg, s2_rel_next;
    logic [LEN_W-1:0]  s2_ramp_reg, s2_ramp_next;

    always_comb begin
        s2_tag_next   = s1_tag_reg;
        s2_phase_next = {start_phase_reg, {(STEP_W-SPH_W){1'b0}}} + s1_phinc_reg;
        s2_att_next   = (s1_att_reg > s1_ramp_reg) ? s1_ramp_reg : s1_att_reg;
        s2_rel_next   = (s1_rel_reg > {1'b0, s1_ramp_reg}) ? s1_ramp_reg
                                                            : s1_rel_reg[LEN_W-1:0];
        s2_ramp_next  = s1_ramp_reg;
    end

    // ------------------------------------------------------------------------
    // Stage 3: table index and the envelope numerator and denominator.
    // ------------------------------------------------------------------------
    logic [KP_W-1:0]   k_full;

    stbg_tag_t         s3_tag_reg, s3_tag_next;
    logic [K_W-1:0]    s3_k_reg, s3_k_next;
    logic [PROD_W-1:0] s3_num_reg, s3_num_next;
    logic [PROD_W-1:0] s3_den_reg, s3_den_next;

    assign k_full = KP_W'(s2_phase_reg) * KP_W'(SINE_TABLE_DEPTH);

    always_comb begin
        s3_tag_next = s2_tag_reg;
        s3_k_next   = k_full[STEP_W +: K_W];
        s3_num_next = PROD_W'(s2_att_reg) * PROD_W'(s2_rel_reg);
        s3_den_next = PROD_W'(s2_ramp_reg) * PROD_W'(s2_ramp_reg);
    end

    // ------------------------------------------------------------------------
    // Stage 4: quadrant folding. The index is below five quarter lengths, so
    // the quadrant comes from four constant compares.
    // ------------------------------------------------------------------------
    logic [K_W:0]      k_ext;
    logic [K_W:0]      k_off;
    logic [1:0]        quad;
    logic [K_W:0]      r_full;
    logic [ROM_AW-1:0] r_addr;

    stbg_tag_t         s4_tag_reg, s4_tag_next;
    logic [ROM_AW-1:0] s4_addr_reg, s4_addr_next;
    logic [PROD_W-1:0] s4_num_reg, s4_num_next;
    logic [PROD_W-1:0] s4_den_reg, s4_den_next;

    assign k_ext = {1'b0, s3_k_reg};

    always_comb begin
        if (k_ext >= QTR4) begin
            quad  = 2'd0;
            k_off = QTR4;
        end else if (k_ext >= QTR3) begin
            quad  = 2'd3;
            k_off = QTR3;
        end else if (k_ext >= QTR2) begin
            quad  = 2'd2;
            k_off = QTR2;
        end else if (k_ext >= QTR1) begin
            quad  = 2'd1;
            k_off = QTR1;
        end else begin
            quad  = 2'd0;
            k_off = '0;
        end
        r_full = k_ext - k_off;
        r_addr = r_full[ROM_AW-1:0];

        s4_tag_next     = s3_tag_reg;
        // Second half of the turn is the negative lobe.
        s4_tag_next.neg = quad[1];
        // Odd quadrants run the table backwards.
        s4_addr_next    = quad[0] ? (QTR_A - r_addr) : r_addr;
        s4_num_next     = s3_num_reg;
        s4_den_next     = s3_den_reg;
    end

    // ------------------------------------------------------------------------
    // Stage 5: quarter-wave table read.
    // ------------------------------------------------------------------------
    logic [MAG_W-1:0] sine_rom [0:QTR];

    for (genvar g = 0; g <= QTR; g++) begin : g_rom
        assign sine_rom[g] = sine_entry(g);
    end

    stbg_tag_t         s5_tag_reg, s5_tag_next;
    logic [PROD_W-1:0] s5_num_reg, s5_num_next;
    logic [PROD_W-1:0] s5_den_reg, s5_den_next;

    always_comb begin
        s5_tag_next     = s4_tag_reg;
        s5_tag_next.mag = sine_rom[s4_addr_reg];
        s5_num_next     = s4_num_reg;
        s5_den_next     = s4_den_reg;
    end

    // ------------------------------------------------------------------------
    // Envelope divider: attack times release over ramp squared, in Q16.
    // ------------------------------------------------------------------------
    logic [ENV_W-1:0] div_env;
    stbg_tag_t        div_tag;

    stbg_env_div u_env_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .num_i   (s5_num_reg),
        .den_i   (s5_den_reg),
        .tag_i   (s5_tag_reg),
        .env_o   (div_env),
        .tag_o   (div_tag)
    );

    // ------------------------------------------------------------------------
    // Tone stages: sine times amplitude, times envelope, then divide by full
    // scale times 2^16 with truncation; zero outside the burst window.
    // ------------------------------------------------------------------------
    stbg_tag_t              t1_tag_reg, t1_tag_next;
    logic [MA_W-1:0]        t1_ma_reg, t1_ma_next;
    logic [ENV_W-1:0]       t1_env_reg, t1_env_next;

    stbg_tag_t              t2_tag_reg, t2_tag_next;
    logic [TONE_PROD_W-1:0] t2_p_reg, t2_p_next;

    logic [X_W-1:0]         tone_x;
    logic [XH_W-1:0]        tone_hi;
    logic [MAG_W-1:0]       tone_lo;
    logic [XH_W:0]          tone_ab;
    logic                   tone_carry;
    logic [MAG_W-1:0]       tone_mag;

    stbg_tag_t              t3_tag_reg, t3_tag_next;
    logic [MAG_W-1:0]       t3_tone_reg, t3_tone_next;

    always_comb begin
        t1_tag_next = div_tag;
        t1_ma_next  = MA_W'(div_tag.mag) * MA_W'(peak_amp_reg);
        t1_env_next = div_env;

        t2_tag_next = t1_tag_reg;
        t2_p_next   = TONE_PROD_W'(t1_ma_reg) * TONE_PROD_W'(t1_env_reg);

        // x / (2^15 - 1) with x = hi * 2^15 + lo equals hi plus one when
        // hi + lo reaches full scale; x never exceeds full scale squared, so
        // at most one correction is needed.
        tone_x     = t2_p_reg[TONE_PROD_W-1:ENV_FRAC];
        tone_hi    = tone_x[X_W-1:MAG_W];
        tone_lo    = tone_x[MAG_W-1:0];
        tone_ab    = (XH_W+1)'(tone_hi) + (XH_W+1)'(tone_lo);
        tone_carry = (tone_ab >= (XH_W+1)'(FULL_SCALE));
        tone_mag   = tone_hi[MAG_W-1:0] + MAG_W'(tone_carry);

        t3_tag_next  = t2_tag_reg;
        t3_tone_next = t2_tag_reg.win ? tone_mag : '0;
    end

    // ------------------------------------------------------------------------
    // Stage registers. Only the valid bits are reset.
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tag_reg.valid <= 1'b0;
            s2_tag_reg.valid <= 1'b0;
            s3_tag_reg.valid <= 1'b0;
            s4_tag_reg.valid <= 1'b0;
            s5_tag_reg.valid <= 1'b0;
            t1_tag_reg.valid <= 1'b0;
            t2_tag_reg.valid <= 1'b0;
            t3_tag_reg.valid <= 1'b0;
        end else if (pipe_en) begin
            s1_tag_reg <= s1_tag_next;
            s2_tag_reg <= s2_tag_next;
            s3_tag_reg <= s3_tag_next;
            s4_tag_reg <= s4_tag_next;
            s5_tag_reg <= s5_tag_next;
            t1_tag_reg <= t1_tag_next;
            t2_tag_reg <= t2_tag_next;
            t3_tag_reg <= t3_tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_phinc_reg <= s1_phinc_next;
            s1_att_reg   <= s1_att_next;
            s1_rel_reg   <= s1_rel_next;
            s1_ramp_reg  <= s1_ramp_next;
            s2_phase_reg <= s2_phase_next;
            s2_att_reg   <= s2_att_next;
            s2_rel_reg   <= s2_rel_next;
            s2_ramp_reg  <= s2_ramp_next;
            s3_k_reg     <= s3_k_next;
            s3_num_reg   <= s3_num_next;
            s3_den_reg   <= s3_den_next;
            s4_addr_reg  <= s4_addr_next;
            s4_num_reg   <= s4_num_next;
            s4_den_reg   <= s4_den_next;
            s5_num_reg   <= s5_num_next;
            s5_den_reg   <= s5_den_next;
            t1_ma_reg    <= t1_ma_next;
            t1_env_reg   <= t1_env_next;
            t2_p_reg     <= t2_p_next;
            t3_tone_reg  <= t3_tone_next;
        end
    end

    // ------------------------------------------------------------------------
    // Mix, saturate, and hand over through the output and skid registers.
    // ------------------------------------------------------------------------
    logic signed [SAMPLE_W:0]   tone_s;
    logic signed [SAMPLE_W:0]   mix_sum;
    logic signed [SAMPLE_W-1:0] sat_sum;

    logic                       m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0] m_data_reg, m_data_next;
    logic                       skid_valid_next;
    logic signed [SAMPLE_W-1:0] skid_data_reg, skid_data_next;

    always_comb begin
        tone_s  = signed'({2'b00, t3_tone_reg});
        mix_sum = SAMPLE_W'(t3_tag_reg.mix) + (t3_tag_reg.neg ? -tone_s : tone_s);
        mix_sum = {t3_tag_reg.mix[SAMPLE_W-1], t3_tag_reg.mix}
                + (t3_tag_reg.neg ? -tone_s : tone_s);
        if (mix_sum > SUM_MAX) begin
            sat_sum = SUM_MAX[SAMPLE_W-1:0];
        end else if (mix_sum < SUM_MIN) begin
            sat_sum = SUM_MIN[SAMPLE_W-1:0];
        end else begin
            sat_sum = mix_sum[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            // Drain the parked result; the pipeline is frozen meanwhile.
            if (m_ready) begin
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (t3_tag_reg.valid) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_next = 1'b1;
                m_data_next  = sat_sum;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = sat_sum;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_data_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`ifndef SYNTHESIS
    // A result is parked only behind a result that is already presented.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register holds a result while the output is empty");

    // The skid register fills only when the presented result was refused.
    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid register filled without an output stall");

    // A frozen pipeline keeps its last stage untouched.
    a_freeze_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> ($stable(t3_tag_reg.valid) && $stable(t3_tone_reg)))
        else $error("pipeline advanced while frozen");

    // The envelope is a fraction of one.
    a_env_range: assert property (@(posedge aclk) disable iff (!aresetn)
        div_tag.valid |-> (div_env <= ENV_ONE))
        else $error("envelope above unity");
`endif

endmodule : sine_tone_burst_generator
`default_nettype wire

@@ hw/rtl/stbg_env_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stbg_env_div
// Pipelined restoring divider for the burst envelope: one quotient bit per
// stage, giving floor(num * 2^16 / den) for num <= den.
// ----------------------------------------------------------------------------
module stbg_env_div import stbg_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic [PROD_W-1:0] num_i,
    input  wire logic [PROD_W-1:0] den_i,
    input  wire stbg_tag_t         tag_i,
    output logic      [ENV_W-1:0]  env_o,
    output stbg_tag_t              tag_o
);

    localparam int STAGES = ENV_W;

    logic      [PROD_W-1:0] rem_reg  [STAGES];
    logic      [PROD_W-1:0] rem_next [STAGES];
    logic      [PROD_W-1:0] den_reg  [STAGES];
    logic      [PROD_W-1:0] den_next [STAGES];
    logic      [ENV_W-1:0]  quo_reg  [STAGES];
    logic      [ENV_W-1:0]  quo_next [STAGES];
    stbg_tag_t              tag_reg  [STAGES];
    stbg_tag_t              tag_next [STAGES];

    logic [PROD_W:0] trial [STAGES];
    logic [PROD_W:0] diff  [STAGES];
    logic            ge    [STAGES];

    always_comb begin
        // The top quotient bit: the numerator never exceeds the denominator.
        trial[0]    = {1'b0, num_i};
        diff[0]     = trial[0] - {1'b0, den_i};
        ge[0]       = (num_i >= den_i);
        rem_next[0] = ge[0] ? diff[0][PROD_W-1:0] : num_i;
        quo_next[0] = ENV_W'(ge[0]);
        den_next[0] = den_i;
        tag_next[0] = tag_i;
        for (int s = 1; s < STAGES; s++) begin
            trial[s]    = {rem_reg[s-1], 1'b0};
            diff[s]     = trial[s] - {1'b0, den_reg[s-1]};
            ge[s]       = (trial[s] >= {1'b0, den_reg[s-1]});
            rem_next[s] = ge[s] ? diff[s][PROD_W-1:0] : trial[s][PROD_W-1:0];
            quo_next[s] = {quo_reg[s-1][ENV_W-2:0], ge[s]};
            den_next[s] = den_reg[s-1];
            tag_next[s] = tag_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < STAGES; s++) begin
                tag_reg[s].valid <= 1'b0;
            end
        end else if (en) begin
            for (int s = 0; s < STAGES; s++) begin
                tag_reg[s] <= tag_next[s];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < STAGES; s++) begin
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_next[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    assign env_o = quo_reg[STAGES-1];
    assign tag_o = tag_reg[STAGES-1];

endmodule : stbg_env_div
`default_nettype wire
